FILE: sv/sqd_pkg.sv
// ----------------------------------------------------------------------------
// sqd_pkg
// Shared constants, types and helper functions of the square QAM Gray
// demapper.
// ----------------------------------------------------------------------------
`default_nettype none

package sqd_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int MAX_AXIS_BITS   = 5;
    localparam int FRAC_BITS       = 8;
    localparam int AB_WIDTH        = 3;
    localparam int AB_RESET        = 2;

    // offset sum must hold a sample plus the largest h << FRAC_BITS, with sign
    localparam int OFS_WIDTH = MAX_AXIS_BITS + FRAC_BITS + 1;
    localparam int T_WIDTH   = ((SAMPLE_WIDTH > OFS_WIDTH) ? SAMPLE_WIDTH : OFS_WIDTH) + 2;
    localparam int UNIT2     = 2 ** (FRAC_BITS + 1);
    localparam int Q_WIDTH   = T_WIDTH - 1 - (FRAC_BITS + 1);

    localparam int SYM_WIDTH  = 2 * MAX_AXIS_BITS;
    localparam int IN_TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SYM_WIDTH + 7) / 8) * 8;

    typedef logic [MAX_AXIS_BITS-1:0] t_idx;
    typedef logic [AB_WIDTH-1:0]      t_ab;

    typedef struct packed {
        logic ld_a;
        logic ld_b;
        logic ld_c;
    } t_pipe_ctl;

    // clamp the register value to the supported range of bits per axis
    function automatic t_ab eff_axis_bits(input t_ab ab);
        t_ab res;
        res = ab;
        if (ab < t_ab'(1)) begin
            res = t_ab'(1);
        end else if (ab > t_ab'(MAX_AXIS_BITS)) begin
            res = t_ab'(MAX_AXIS_BITS);
        end
        return res;
    endfunction

    // highest level index h-1
    function automatic t_idx top_index(input t_ab ab);
        logic [MAX_AXIS_BITS:0] h;
        h = (MAX_AXIS_BITS+1)'(1) << ab;
        return t_idx'(h - (MAX_AXIS_BITS+1)'(1));
    endfunction

    function automatic t_idx gray(input t_idx n);
        return n ^ (n >> 1);
    endfunction

endpackage

`default_nettype wire

FILE: sv/sqd_axis_slicer.sv
// ----------------------------------------------------------------------------
// sqd_axis_slicer
// Two register stages that slice one axis to the nearest odd level index:
// offset add, then quotient, tie-low rounding and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module sqd_axis_slicer (
    input  wire logic                                     i_clk,
    input  wire sqd_pkg::t_pipe_ctl                       i_ctl,
    input  wire sqd_pkg::t_ab                             i_axis_bits,
    input  wire logic signed [sqd_pkg::SAMPLE_WIDTH-1:0]  i_sample,
    output sqd_pkg::t_idx                                 o_index
);
    import sqd_pkg::*;

    logic signed [T_WIDTH-1:0] r_t;
    logic signed [T_WIDTH-1:0] n_t;
    t_idx                      r_k;
    t_idx                      n_k;
    logic [T_WIDTH-1:0]        w_ofs;
    logic [Q_WIDTH-1:0]        w_q;
    logic [Q_WIDTH-1:0]        w_qm1;
    t_idx                      w_top;

    // t = x + (h << FRAC_BITS) + UNIT2 - 1
    always_comb begin
        w_ofs = (T_WIDTH'(1) << (FRAC_BITS + int'(i_axis_bits)));
        n_t   = T_WIDTH'(i_sample) + $signed(w_ofs) + $signed(T_WIDTH'(UNIT2 - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_a) begin
            r_t <= n_t;
        end
    end

    // k = t / UNIT2 - 1, zero below one step, clamped to h-1
    always_comb begin
        w_top = top_index(i_axis_bits);
        w_q   = r_t[T_WIDTH-2:FRAC_BITS+1];
        w_qm1 = w_q - Q_WIDTH'(1);
        if (r_t < $signed(T_WIDTH'(UNIT2))) begin
            n_k = '0;
        end else if (w_qm1 > Q_WIDTH'(w_top)) begin
            n_k = w_top;
        end else begin
            n_k = t_idx'(w_qm1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_b) begin
            r_k <= n_k;
        end
    end

    assign o_index = r_k;

endmodule

`default_nettype wire

FILE: sv/sqd_gray_pack.sv
// ----------------------------------------------------------------------------
// sqd_gray_pack
// Output stage: Gray-codes both level indexes and packs the symbol bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sqd_gray_pack (
    input  wire logic                              i_clk,
    input  wire sqd_pkg::t_pipe_ctl                i_ctl,
    input  wire sqd_pkg::t_ab                      i_axis_bits,
    input  wire sqd_pkg::t_idx                     i_real_index,
    input  wire sqd_pkg::t_idx                     i_imag_index,
    output logic [sqd_pkg::SYM_WIDTH-1:0]          o_symbol_bits
);
    import sqd_pkg::*;

    logic [SYM_WIDTH-1:0] r_sym;
    logic [SYM_WIDTH-1:0] n_sym;

    // imaginary axis is labeled from the top level down
    always_comb begin
        n_sym = (SYM_WIDTH'(gray(i_real_index)) << i_axis_bits)
              | SYM_WIDTH'(gray(top_index(i_axis_bits) - i_imag_index));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_c) begin
            r_sym <= n_sym;
        end
    end

    assign o_symbol_bits = r_sym;

endmodule

`default_nettype wire

FILE: sv/square_qam_gray_demapper.sv
// ----------------------------------------------------------------------------
// square_qam_gray_demapper
// Hard-decision demapper for square QAM with Gray labeling.
//
// Input stream: one complex sample per request, Q7.8 real part in the low
// half of tdata, imaginary part in the high half. Output stream: the symbol
// bits, Gray(real index) above Gray(h-1-imag index), zero above 2*axis_bits.
// Config channel: writes axis_bits (1..5, others clamp); always ready. Write
// it only while no sample is in flight.
// From input handshake to output valid a sample passes three register
// stages: offset add, quotient and clamp, Gray pack. Throughput is one
// sample per cycle while the output takes results; each stage holds its data
// while the stage after it is full, so an output stall backs up through the
// three stages to the input tready without losing or repeating anything.
// Reset empties the pipeline and sets axis_bits to 2 (16-QAM).
// ----------------------------------------------------------------------------
`default_nettype none

module square_qam_gray_demapper (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sqd_pkg::AB_WIDTH-1:0]        i_cfg_data,
    // slave stream
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [sqd_pkg::IN_TDATA_W-1:0]      i_s_tdata,  // sample_real, sample_imag
    // master stream
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [sqd_pkg::OUT_TDATA_W-1:0]          o_m_tdata   // symbol_bits, zero pad
);
    import sqd_pkg::*;

    t_ab       r_axis_bits;
    t_ab       w_ab;
    logic      r_vld_a;
    logic      r_vld_b;
    logic      r_vld_c;
    logic      w_rdy_a;
    logic      w_rdy_b;
    logic      w_rdy_c;
    t_pipe_ctl w_ctl;
    t_idx      w_real_index;
    t_idx      w_imag_index;
    logic [SYM_WIDTH-1:0] w_sym;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_bits <= t_ab'(AB_RESET);
        end else if (i_cfg_valid) begin
            r_axis_bits <= i_cfg_data;
        end
    end

    assign w_ab = eff_axis_bits(r_axis_bits);

    // a stage takes new data when it is empty or drains this cycle
    assign w_rdy_c = !r_vld_c || i_m_tready;
    assign w_rdy_b = !r_vld_b || w_rdy_c;
    assign w_rdy_a = !r_vld_a || w_rdy_b;

    assign w_ctl.ld_a = w_rdy_a;
    assign w_ctl.ld_b = w_rdy_b;
    assign w_ctl.ld_c = w_rdy_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_vld_a <= i_s_tvalid;
            end
            if (w_rdy_b) begin
                r_vld_b <= r_vld_a;
            end
            if (w_rdy_c) begin
                r_vld_c <= r_vld_b;
            end
        end
    end

    sqd_axis_slicer u_real (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_axis_bits (w_ab),
        .i_sample    (i_s_tdata[SAMPLE_WIDTH-1:0]),
        .o_index     (w_real_index)
    );

    sqd_axis_slicer u_imag (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_axis_bits (w_ab),
        .i_sample    (i_s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .o_index     (w_imag_index)
    );

    sqd_gray_pack u_pack (
        .i_clk         (i_clk),
        .i_ctl         (w_ctl),
        .i_axis_bits   (w_ab),
        .i_real_index  (w_real_index),
        .i_imag_index  (w_imag_index),
        .o_symbol_bits (w_sym)
    );

    assign o_s_tready = w_rdy_a;
    assign o_m_tvalid = r_vld_c;
    assign o_m_tdata  = OUT_TDATA_W'(w_sym);

endmodule

`default_nettype wire

FILE: sv/sqd_checker.sv
// ----------------------------------------------------------------------------
// sqd_checker
// Port-level assertions for the square QAM Gray demapper, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sqd_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_s_tvalid,
    input wire logic                                o_s_tready,
    input wire logic                                o_m_tvalid,
    input wire logic                                i_m_tready,
    input wire logic [sqd_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);
    import sqd_pkg::*;

    // hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    a_valid_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_m_tvalid) |-> $past(i_m_tready))
        else $error("result dropped without handshake");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OUT_TDATA_W-1:SYM_WIDTH] == '0))
        else $error("padding bits of result not zero");

    // with no stall, an accepted request reaches the output after three stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_m_tready ##1 i_m_tready ##1 i_m_tready)
        |=> o_m_tvalid)
        else $error("request did not reach output in three cycles");

endmodule

bind square_qam_gray_demapper sqd_checker u_sqd_checker (.*);

`default_nettype wire

FILE: tb/sqd_checker.sv
// ----------------------------------------------------------------------------
// tb_sqd_checker
// Watches the config, sample and symbol channels of the square QAM Gray
// demapper. Each accepted sample is sliced here on both axes with the current
// axis_bits setting, and the expected symbol is queued. Each accepted symbol
// is then compared with the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sqd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [sqd_pkg::AB_WIDTH-1:0]    i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [sqd_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // sample_real, sample_imag
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [sqd_pkg::OUT_TDATA_W-1:0] i_m_tdata,   // symbol_bits, zero pad
    output int                              o_outstanding,
    output int                              o_errors
);
    import sqd_pkg::*;

    logic [OUT_TDATA_W-1:0] expected_syms[$];
    logic [AB_WIDTH-1:0]    axis_bits_reg;
    logic [OUT_TDATA_W-1:0] want_sym;
    int                     mismatches = 0;

    // level index k covers (2k-h, 2k-h+2] in units of 1.0; ties fall low
    function automatic int slice_level(input logic signed [SAMPLE_WIDTH-1:0] x,
                                       input int h);
        int t;
        int k;
        t = int'(x) + (h << FRAC_BITS) + (1 << (FRAC_BITS + 1)) - 1;
        if (t < (1 << (FRAC_BITS + 1))) begin
            return 0;
        end
        k = t / (1 << (FRAC_BITS + 1)) - 1;
        if (k > h - 1) begin
            k = h - 1;
        end
        return k;
    endfunction

    function automatic int gray_code(input int n);
        return n ^ (n >> 1);
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] demap_symbol(input logic [AB_WIDTH-1:0] ab_reg,
                                                            input logic [IN_TDATA_W-1:0] tdata);
        int ab;
        int h;
        int re_idx;
        int im_idx;
        int sym;
        ab = int'(ab_reg);
        if (ab < 1) begin
            ab = 1;
        end else if (ab > MAX_AXIS_BITS) begin
            ab = MAX_AXIS_BITS;
        end
        h = 1 << ab;
        re_idx = slice_level(tdata[SAMPLE_WIDTH-1:0], h);
        im_idx = slice_level(tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH], h);
        sym = (gray_code(re_idx) << ab) | gray_code(h - 1 - im_idx);
        return OUT_TDATA_W'(sym);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_syms.delete();
            axis_bits_reg = AB_WIDTH'(AB_RESET);
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_syms.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected symbol: expected none, actual %h",
                             $time, i_m_tdata);
                end else begin
                    want_sym = expected_syms.pop_front();
                    if (i_m_tdata !== want_sym) begin
                        mismatches++;
                        $display("%0t: symbol mismatch: expected %h, actual %h",
                                 $time, want_sym, i_m_tdata);
                    end
                end
            end
            // slice with the setting in force before any write at this edge
            if (i_s_tvalid && i_s_tready) begin
                expected_syms.push_back(demap_symbol(axis_bits_reg, i_s_tdata));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                axis_bits_reg = i_cfg_data;
            end
        end
        o_outstanding <= expected_syms.size();
        o_errors      <= mismatches;
    end

endmodule

FILE: tb/tb_square_qam_gray_demapper.sv
// ----------------------------------------------------------------------------
// tb_square_qam_gray_demapper
// Drives the square QAM Gray demapper with directed corner samples and then
// random phases over every axis_bits value, with random gaps on both streams
// and one long output stall. A checker beside the block predicts the symbols
// and counts failures; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_square_qam_gray_demapper;
    import sqd_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 163;
    localparam int DRAIN_CYCLES = 10;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   cfg_valid  = 1'b0;
    logic [AB_WIDTH-1:0]    cfg_data   = '0;
    logic                   s_tvalid   = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata    = '0;
    logic                   m_tready   = 1'b0;
    logic                   o_cfg_ready;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    int outstanding;
    int errors;

    bit tx_idle_en    = 1'b1;
    bit rx_idle_en    = 1'b1;
    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;
    int cur_h         = 1 << AB_RESET;

    int phase_settings[10] = '{0, 1, 5, 7, 3, 6, 4, 2, 5, 2};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    square_qam_gray_demapper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    tb_sqd_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (o_m_tdata),
        .o_outstanding (outstanding),
        .o_errors      (errors)
    );

    // offer one sample and return at the edge that accepts it
    task automatic push_sample(input int re, input int im);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {SAMPLE_WIDTH'(im), SAMPLE_WIDTH'(re)};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // drop the request and wait until every symbol has come out
    task automatic drain_symbols();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_axis_bits(input int value);
        int ab;
        drain_symbols();
        cfg_valid <= 1'b1;
        cfg_data  <= AB_WIDTH'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        ab = (value < 1) ? 1 : ((value > MAX_AXIS_BITS) ? MAX_AXIS_BITS : value);
        cur_h = 1 << ab;
    endtask

    // mostly near the constellation and on its decision boundaries
    function automatic int random_axis(input int h);
        int k;
        k = $urandom_range(0, h);
        case ($urandom_range(0, 9))
            0, 1: return int'($signed(SAMPLE_WIDTH'($urandom)));
            2, 3: return (2 * k - h) << FRAC_BITS;
            4:    return ((2 * k - h) << FRAC_BITS) + (($urandom_range(0, 1) != 0) ? 1 : -1);
            5:    return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            default: begin
                return $urandom_range(0, 2 * (h + 1) << FRAC_BITS) - ((h + 1) << FRAC_BITS);
            end
        endcase
    endfunction

    // output side: random ready bursts, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #5ms;
        $display("tb_square_qam_gray_demapper NOT OK");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting, 16-QAM: extremes, ties, exact levels, clamping
        push_sample(-32768, 32767);
        push_sample(32767, -32768);
        push_sample(0, 0);
        push_sample(-512, -512);
        push_sample(512, 512);
        push_sample(-511, 511);
        push_sample(1, -1);
        push_sample(-768, 768);
        push_sample(-1024, 1024);
        push_sample(-1025, 1025);
        push_sample(16'h5555, 16'hAAAA);
        push_sample(-256, 256);

        // largest constellation
        write_axis_bits(MAX_AXIS_BITS);
        push_sample(-32768, 32767);
        push_sample(-8192, 8192);
        push_sample(-8191, 8191);
        push_sample(-7936, 7936);
        push_sample(0, 0);

        // zero setting falls back to QPSK
        write_axis_bits(0);
        push_sample(0, 0);
        push_sample(1, -1);
        push_sample(-256, 256);
        push_sample(32767, -32768);

        foreach (phase_settings[p]) begin
            write_axis_bits(phase_settings[p]);
            if (p == 4) begin
                // keep offering while the output holds off, so the input backs up
                tx_idle_en   = 1'b0;
                hold_off_req = 1'b1;
            end else if (p == $size(phase_settings) - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end else begin
                tx_idle_en = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                push_sample(random_axis(cur_h), random_axis(cur_h));
            end
        end

        drain_symbols();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && outstanding == 0) begin
            $display("tb_square_qam_gray_demapper OK");
        end else begin
            $display("tb_square_qam_gray_demapper NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/sqd_pkg.sv
sv/sqd_axis_slicer.sv
sv/sqd_gray_pack.sv
sv/square_qam_gray_demapper.sv
sv/sqd_checker.sv
tb/sqd_checker.sv
tb/tb_square_qam_gray_demapper.sv
